>>> design/irpd_pkg.sv
// Package for the IR pulse-distance decoder: item and result types, register
// indexes, reset values and frame constants. No dependencies.
package irpd_pkg;

	localparam int TICK_W    = 16;
	localparam int FRAME_BITS = 32;
	localparam int BIT_CNT_W = $clog2(FRAME_BITS);
	localparam int NUM_BYTES = FRAME_BITS / 8;
	localparam int BYTE_IDX_W = $clog2(NUM_BYTES);
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_LEAD_MIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN = 3'd4;

	localparam logic [TICK_W-1:0] LEAD_MIN_RST = 16'd8000;
	localparam logic [TICK_W-1:0] LEAD_MAX_RST = 16'd14000;
	localparam logic [TICK_W-1:0] ONE_MIN_RST  = 16'd1450;
	localparam logic [TICK_W-1:0] ONE_MAX_RST  = 16'd3000;
	localparam logic [TICK_W-1:0] ZERO_MIN_RST = 16'd700;

	localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(FRAME_BITS - 1);

	typedef struct packed {
		logic [TICK_W-1:0] lead_min;
		logic [TICK_W-1:0] lead_max;
		logic [TICK_W-1:0] one_min;
		logic [TICK_W-1:0] one_max;
		logic [TICK_W-1:0] zero_min;
	} cfg_t;

	typedef struct packed {
		logic [TICK_W-1:0] interval;
	} interval_t;

	typedef struct packed {
		logic       frame_done;
		logic       frame_ok;
		logic [7:0] address_byte;
		logic [7:0] address_check_byte;
		logic [7:0] command_byte;
		logic [7:0] command_inverse_byte;
		logic       receiving;
	} result_t;

	// Classification of one interval against the windows.
	typedef struct packed {
		logic lead;
		logic one;
		logic zero;
	} bit_class_t;

endpackage

>>> design/irpd_stream_if.sv
// Valid/ready channel carrying one payload item per handshake.
// Depends on nothing; payload type is set by the instantiating code.
interface irpd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> design/ir_pulse_distance_decoder_top.sv
// IR pulse-distance frame decoder, one result item per interval item.
// Path: an accepted interval passes the input register, then the result register; a stall
// on results can hold it in the input register. Frame state updates with the result register.
// Throughput: 1 item per cycle while results is ready; the compare-and-shift sits between the registers.
// Reset: windows return to their defaults, frame state and bytes clear.
module ir_pulse_distance_decoder_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [irpd_pkg::TICK_W-1:0]    cfg_data,
	irpd_stream_if.sink                    intervals,
	irpd_stream_if.source                  results
);

	irpd_pkg::cfg_t       cfg_q;
	logic                 valid_s1;
	irpd_pkg::interval_t  item_s1;
	logic                 out_valid_q;
	logic                 advance;
	irpd_pkg::bit_class_t cls;
	irpd_pkg::result_t    result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lead_min <= irpd_pkg::LEAD_MIN_RST;
			cfg_q.lead_max <= irpd_pkg::LEAD_MAX_RST;
			cfg_q.one_min  <= irpd_pkg::ONE_MIN_RST;
			cfg_q.one_max  <= irpd_pkg::ONE_MAX_RST;
			cfg_q.zero_min <= irpd_pkg::ZERO_MIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				irpd_pkg::REG_LEAD_MIN: cfg_q.lead_min <= cfg_data;
				irpd_pkg::REG_LEAD_MAX: cfg_q.lead_max <= cfg_data;
				irpd_pkg::REG_ONE_MIN:  cfg_q.one_min  <= cfg_data;
				irpd_pkg::REG_ONE_MAX:  cfg_q.one_max  <= cfg_data;
				irpd_pkg::REG_ZERO_MIN: cfg_q.zero_min <= cfg_data;
				default: ;
			endcase
		end
	end

	// Move the staged item into the result register when that register frees up.
	assign advance         = valid_s1 && (!out_valid_q || results.ready);
	assign intervals.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (intervals.ready)
				valid_s1 <= intervals.valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (intervals.valid && intervals.ready)
			item_s1 <= intervals.payload;
	end

	irpd_classify u_classify (
		.interval (item_s1.interval),
		.cfg      (cfg_q),
		.cls      (cls)
	);

	irpd_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.cls      (cls),
		.result_q (result_q)
	);

	assign results.valid   = out_valid_q;
	assign results.payload = result_q;

	// A completed frame always closes it.
	a_done_closes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.frame_done |-> !result_q.receiving)
		else $error("frame_done with receiving still set");

	// The check flag follows the command and inverse bytes, only on frame end.
	a_ok_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.frame_ok ==
			(result_q.frame_done &&
			 (result_q.command_byte == ~result_q.command_inverse_byte))))
		else $error("frame_ok inconsistent with bytes");

	// A staged item that cannot advance stays staged.
	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("staged interval lost under stall");

endmodule

>>> design/irpd_classify.sv
// Window compare of one interval against the leader, one and zero bounds.
// Depends on irpd_pkg.
module irpd_classify (
	input  logic [irpd_pkg::TICK_W-1:0] interval,
	input  irpd_pkg::cfg_t              cfg,
	output irpd_pkg::bit_class_t        cls
);

	// All bounds are exclusive; an empty or inverted window never matches.
	always_comb begin
		cls.lead = (interval > cfg.lead_min) && (interval < cfg.lead_max);
		cls.one  = (interval > cfg.one_min)  && (interval < cfg.one_max);
		cls.zero = (interval > cfg.zero_min) && (interval < cfg.one_min);
	end

endmodule

>>> design/irpd_frame.sv
// Frame state (in-frame flag, bit count, four shift bytes) and result register.
// Depends on irpd_pkg.
module irpd_frame (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  irpd_pkg::bit_class_t cls,
	output irpd_pkg::result_t    result_q
);

	logic                           in_frame_q;
	logic [irpd_pkg::BIT_CNT_W-1:0] bit_count_q;
	logic [7:0]                     bytes_q [irpd_pkg::NUM_BYTES];

	logic                            in_frame_d;
	logic [irpd_pkg::BIT_CNT_W-1:0]  bit_count_d;
	logic [7:0]                      bytes_d [irpd_pkg::NUM_BYTES];
	logic [irpd_pkg::BYTE_IDX_W-1:0] byte_idx;
	logic                            take_bit;
	logic                            done;
	irpd_pkg::result_t               result_d;

	assign byte_idx = bit_count_q[irpd_pkg::BIT_CNT_W-1 -: irpd_pkg::BYTE_IDX_W];
	assign take_bit = !cls.lead && in_frame_q && (cls.one || cls.zero);
	assign done     = take_bit && (bit_count_q == irpd_pkg::LAST_BIT);

	always_comb begin
		in_frame_d  = in_frame_q;
		bit_count_d = bit_count_q;
		bytes_d     = bytes_q;
		if (cls.lead) begin
			in_frame_d  = 1'b1;
			bit_count_d = '0;
		end else if (take_bit) begin
			// shift in LSB first: new bit enters at the top
			bytes_d[byte_idx] = {cls.one, bytes_q[byte_idx][7:1]};
			bit_count_d       = bit_count_q + 1'b1;
			if (done)
				in_frame_d = 1'b0;
		end
	end

	always_comb begin
		result_d.frame_done           = done;
		result_d.frame_ok             = done && (bytes_d[2] == ~bytes_d[3]);
		result_d.address_byte         = bytes_d[0];
		result_d.address_check_byte   = bytes_d[1];
		result_d.command_byte         = bytes_d[2];
		result_d.command_inverse_byte = bytes_d[3];
		result_d.receiving            = in_frame_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			bit_count_q <= '0;
			for (int i = 0; i < irpd_pkg::NUM_BYTES; i++)
				bytes_q[i] <= '0;
		end else if (step) begin
			in_frame_q  <= in_frame_d;
			bit_count_q <= bit_count_d;
			bytes_q     <= bytes_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			result_q <= result_d;
	end

endmodule
